/* hdl/assert_macros.svh */
// Assertion helpers shared by the RTL. Both expect clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* hdl/bea_pkg.sv */
`default_nettype none

package bea_pkg;

  // Field widths
  localparam int ADDR_W   = 7;   // block address
  localparam int COUNT_W  = 8;   // block count, up to 128
  localparam int STATUS_W = 2;

  // Default map depth
  localparam int BLOCKS_DEF = 128;

  // Opcodes
  localparam logic OP_ALLOC  = 1'b0;
  localparam logic OP_REPORT = 1'b1;

  // Configuration register indexes
  localparam logic CFG_REGION_FIRST = 1'b0;
  localparam logic CFG_REGION_LAST  = 1'b1;

  // Reset values of the region registers
  localparam logic [ADDR_W-1:0] REGION_FIRST_RST = 7'd0;
  localparam logic [ADDR_W-1:0] REGION_LAST_RST  = 7'd127;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_CONFLICT = 2'd1,
    ST_OUTSIDE  = 2'd2
  } status_t;

  // Controller to datapath commands
  typedef struct packed {
    logic clear;   // clear one map entry
    logic load;    // capture the accepted transaction
    logic check;   // range checks, walk setup
    logic walk;    // one step of the bitmap walk
    logic flush;   // final report result
  } ctl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clear_done;
    logic op_report;
    logic alloc_empty;   // reversed allocate range
    logic alloc_bad;     // allocate range outside region
    logic region_empty;
    logic walk_done;
  } dp_stat_t;

endpackage

`default_nettype wire

/* hdl/bea_ctrl.sv */
`default_nettype none
`include "assert_macros.svh"

module bea_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire bea_pkg::dp_stat_t st,
  output bea_pkg::ctl_cmd_t      cmd
);
  import bea_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_CHECK = 5'b00100,
    S_WALK  = 5'b01000,
    S_FLUSH = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (st.clear_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (st.op_report) begin
          state_nxt = st.region_empty ? S_FLUSH : S_WALK;
        end else if (st.alloc_empty || st.alloc_bad) begin
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        if (st.walk_done) state_nxt = st.op_report ? S_FLUSH : S_IDLE;
      end
      S_FLUSH: begin
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // command decode
  always_comb begin
    cmd.clear = (state_r == S_CLEAR);
    cmd.load  = (state_r == S_IDLE) && start;
    cmd.check = (state_r == S_CHECK);
    cmd.walk  = (state_r == S_WALK);
    cmd.flush = (state_r == S_FLUSH);
  end

  assign busy = (state_r != S_IDLE);

  // an accepted transaction always goes through the range check first
  `ASSERT_NEXT(a_accept_to_check, start && !busy, state_r == S_CHECK)
  // the flush step only follows the check or the walk
  `ASSERT_IMPL(a_flush_entry, state_r == S_FLUSH, $past(state_r) == S_WALK || $past(state_r) == S_CHECK)
  // a walk never starts before the clearing pass is over
  `ASSERT_NEXT(a_clear_exit, state_r == S_CLEAR && !st.clear_done, state_r == S_CLEAR)

endmodule

`default_nettype wire

/* hdl/bea_datapath.sv */
`default_nettype none
`include "assert_macros.svh"

module bea_datapath #(
  parameter int BLOCKS = bea_pkg::BLOCKS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire bea_pkg::ctl_cmd_t              cmd,
  output bea_pkg::dp_stat_t                   st,
  input  wire logic                           cfg_we,
  input  wire logic                           cfg_index,
  input  wire logic [bea_pkg::ADDR_W-1:0]     cfg_data,
  input  wire logic                           in_opcode,
  input  wire logic [bea_pkg::ADDR_W-1:0]     in_first_block,
  input  wire logic [bea_pkg::ADDR_W-1:0]     in_last_block,
  output logic                                out_valid,
  output logic [bea_pkg::STATUS_W-1:0]        out_status,
  output logic [bea_pkg::ADDR_W-1:0]          out_conflict_block,
  output logic [bea_pkg::COUNT_W-1:0]         out_marked_count,
  output logic [bea_pkg::ADDR_W-1:0]          out_run_start,
  output logic [bea_pkg::COUNT_W-1:0]         out_run_length,
  output logic                                out_last
);
  import bea_pkg::*;

  localparam int AW    = $clog2(BLOCKS);
  // highest map entry reachable by a 7-bit block address
  localparam int LIM_V = (BLOCKS > 128) ? 127 : BLOCKS - 1;
  localparam logic [ADDR_W-1:0] LIM7    = ADDR_W'(LIM_V);
  localparam logic [AW-1:0]     CLR_END = AW'(BLOCKS - 1);

  // used/free map, one bit per block
  logic mem [BLOCKS];
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic              mem_wdata;
  logic              rdata_r;

  // configuration
  logic [ADDR_W-1:0] rf_r, rf_nxt;
  logic [ADDR_W-1:0] rl_r, rl_nxt;

  // clearing pass
  logic [AW-1:0]     clr_ptr_r, clr_ptr_nxt;

  // transaction
  logic              op_r, op_nxt;
  logic [ADDR_W-1:0] fb_r, fb_nxt;
  logic [ADDR_W-1:0] lb_r, lb_nxt;

  // walk: issue side and evaluate side
  logic [ADDR_W-1:0] ptr_r, ptr_nxt;
  logic [ADDR_W-1:0] stop_r, stop_nxt;
  logic              iss_done_r, iss_done_nxt;
  logic [ADDR_W-1:0] cur_r;
  logic              cur_vld_r, cur_vld_nxt;
  logic              cur_last_r;
  logic [COUNT_W-1:0] marked_r, marked_nxt;

  // run tracking
  logic [ADDR_W-1:0]  start_r, start_nxt;
  logic [COUNT_W-1:0] len_r, len_nxt;
  logic               pend_vld_r, pend_vld_nxt;
  logic [ADDR_W-1:0]  pend_start_r, pend_start_nxt;
  logic [COUNT_W-1:0] pend_len_r, pend_len_nxt;

  // result register
  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [ADDR_W-1:0]   out_cb_r, out_cb_nxt;
  logic [COUNT_W-1:0]  out_mc_r, out_mc_nxt;
  logic [ADDR_W-1:0]   out_rs_r, out_rs_nxt;
  logic [COUNT_W-1:0]  out_rl_r, out_rl_nxt;
  logic                out_last_r, out_last_nxt;

  // region and range checks
  logic [ADDR_W-1:0] end7;
  logic              reg_empty, rng_empty, rng_bad;
  logic              free_blk;
  logic [COUNT_W-1:0] nlen;
  logic [ADDR_W-1:0]  nstart;
  logic               run_close;

  always_comb begin
    end7      = (rl_r > LIM7) ? LIM7 : rl_r;
    reg_empty = rf_r > end7;
    rng_empty = fb_r > lb_r;
    rng_bad   = (fb_r < rf_r) || (lb_r > end7) || reg_empty;
  end

  // run bookkeeping for the block under evaluation
  always_comb begin
    free_blk  = !rdata_r;
    nlen      = free_blk ? COUNT_W'(len_r + COUNT_W'(1)) : len_r;
    nstart    = (free_blk && (len_r == '0)) ? cur_r : start_r;
    run_close = (rdata_r || cur_last_r) && (nlen != '0);
  end

  // status to controller
  always_comb begin
    st.clear_done   = (clr_ptr_r == CLR_END);
    st.op_report    = op_r;
    st.alloc_empty  = rng_empty;
    st.alloc_bad    = rng_bad;
    st.region_empty = reg_empty;
    st.walk_done    = cur_vld_r && (cur_last_r || ((op_r == OP_ALLOC) && rdata_r));
  end

  // next-state logic
  always_comb begin
    rf_nxt         = rf_r;
    rl_nxt         = rl_r;
    clr_ptr_nxt    = clr_ptr_r;
    op_nxt         = op_r;
    fb_nxt         = fb_r;
    lb_nxt         = lb_r;
    ptr_nxt        = ptr_r;
    stop_nxt       = stop_r;
    iss_done_nxt   = iss_done_r;
    cur_vld_nxt    = 1'b0;
    marked_nxt     = marked_r;
    start_nxt      = start_r;
    len_nxt        = len_r;
    pend_vld_nxt   = pend_vld_r;
    pend_start_nxt = pend_start_r;
    pend_len_nxt   = pend_len_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = ST_OK;
    out_cb_nxt     = '0;
    out_mc_nxt     = '0;
    out_rs_nxt     = '0;
    out_rl_nxt     = '0;
    out_last_nxt   = 1'b0;
    mem_we         = 1'b0;
    mem_waddr      = AW'(cur_r);
    mem_wdata      = 1'b1;

    // configuration writes
    if (cfg_we) begin
      if (cfg_index == CFG_REGION_FIRST) rf_nxt = cfg_data;
      if (cfg_index == CFG_REGION_LAST)  rl_nxt = cfg_data;
    end

    // clearing pass after reset
    if (cmd.clear) begin
      mem_we      = 1'b1;
      mem_waddr   = clr_ptr_r;
      mem_wdata   = 1'b0;
      clr_ptr_nxt = AW'(clr_ptr_r + AW'(1));
    end

    // capture transaction
    if (cmd.load) begin
      op_nxt = in_opcode;
      fb_nxt = in_first_block;
      lb_nxt = in_last_block;
    end

    // range checks and walk setup
    if (cmd.check) begin
      ptr_nxt      = (op_r == OP_REPORT) ? rf_r : fb_r;
      stop_nxt     = (op_r == OP_REPORT) ? end7 : lb_r;
      iss_done_nxt = 1'b0;
      marked_nxt   = '0;
      len_nxt      = '0;
      pend_vld_nxt = 1'b0;
      if (op_r == OP_ALLOC) begin
        if (rng_empty) begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = 1'b1;
        end else if (rng_bad) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OUTSIDE;
          out_last_nxt   = 1'b1;
        end
      end
    end

    if (cmd.walk) begin
      // issue side: one read per cycle until the stop block
      cur_vld_nxt = !iss_done_r;
      if (!iss_done_r) begin
        if (ptr_r == stop_r) iss_done_nxt = 1'b1;
        else                 ptr_nxt = ADDR_W'(ptr_r + ADDR_W'(1));
      end

      // evaluate side: block cur_r with its map bit in rdata_r
      if (cur_vld_r) begin
        if (op_r == OP_ALLOC) begin
          if (rdata_r) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_CONFLICT;
            out_cb_nxt     = cur_r;
            out_mc_nxt     = marked_r;
            out_last_nxt   = 1'b1;
          end else begin
            mem_we     = 1'b1;
            marked_nxt = COUNT_W'(marked_r + COUNT_W'(1));
            if (cur_last_r) begin
              out_valid_nxt = 1'b1;
              out_mc_nxt    = marked_nxt;
              out_last_nxt  = 1'b1;
            end
          end
        end else begin
          // a closed run is held until the next one closes, so the final one can be flagged
          if (run_close) begin
            if (pend_vld_r) begin
              out_valid_nxt = 1'b1;
              out_rs_nxt    = pend_start_r;
              out_rl_nxt    = pend_len_r;
            end
            pend_vld_nxt   = 1'b1;
            pend_start_nxt = nstart;
            pend_len_nxt   = nlen;
            len_nxt        = '0;
          end else begin
            len_nxt = nlen;
          end
          start_nxt = nstart;
        end
      end
    end

    // final report result, or the empty marker
    if (cmd.flush) begin
      out_valid_nxt = 1'b1;
      out_last_nxt  = 1'b1;
      if (pend_vld_r) begin
        out_rs_nxt = pend_start_r;
        out_rl_nxt = pend_len_r;
      end
    end
  end

  // map storage
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata_r <= mem[AW'(ptr_r)];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rf_r        <= REGION_FIRST_RST;
      rl_r        <= REGION_LAST_RST;
      clr_ptr_r   <= '0;
      iss_done_r  <= 1'b1;
      cur_vld_r   <= 1'b0;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rf_r        <= rf_nxt;
      rl_r        <= rl_nxt;
      clr_ptr_r   <= clr_ptr_nxt;
      iss_done_r  <= iss_done_nxt;
      cur_vld_r   <= cur_vld_nxt;
      pend_vld_r  <= pend_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    fb_r         <= fb_nxt;
    lb_r         <= lb_nxt;
    ptr_r        <= ptr_nxt;
    stop_r       <= stop_nxt;
    cur_r        <= ptr_r;
    cur_last_r   <= (ptr_r == stop_r);
    marked_r     <= marked_nxt;
    start_r      <= start_nxt;
    len_r        <= len_nxt;
    pend_start_r <= pend_start_nxt;
    pend_len_r   <= pend_len_nxt;
    out_status_r <= out_status_nxt;
    out_cb_r     <= out_cb_nxt;
    out_mc_r     <= out_mc_nxt;
    out_rs_r     <= out_rs_nxt;
    out_rl_r     <= out_rl_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_conflict_block = out_cb_r;
  assign out_marked_count   = out_mc_r;
  assign out_run_start      = out_rs_r;
  assign out_run_length     = out_rl_r;
  assign out_last           = out_last_r;

  // a held run is never empty
  `ASSERT_IMPL(a_pend_nonzero, pend_vld_r, pend_len_r != '0)
  // a conflict ends the transaction and carries no run
  `ASSERT_IMPL(a_conflict_final, out_valid_r && (out_status_r == ST_CONFLICT), out_last_r && (out_rl_r == '0))
  // the map is only written by the clearing pass or an allocate step
  `ASSERT_IMPL(a_write_src, mem_we, cmd.clear || (cmd.walk && (op_r == OP_ALLOC)))

endmodule

`default_nettype wire

/* hdl/block_bitmap_extent_allocator.sv */
// Bitmap extent allocator. After reset the block clears its used/free map, one
// entry a cycle, holding busy high until the pass is over. A transaction is taken
// when start is high and busy is low. The walk reads one map bit per cycle from
// a map memory with a registered read port and a separate write port. An
// allocate stops early at a conflict and ends after the range check when the
// range is reversed or refused; a report over an empty region goes straight
// from the range check to the final result. Results come out on out_valid, at
// most one per cycle, and must be taken when shown: there is no way to hold
// them off. An allocate gives one result; a report gives one per free run with
// out_last on the final one, or a single zero-length result when nothing is
// free. Configuration writes are only valid while busy is low and no result
// is still due.
`default_nettype none

module block_bitmap_extent_allocator #(
  parameter int BLOCKS = bea_pkg::BLOCKS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic                        in_opcode,
  input  wire logic [bea_pkg::ADDR_W-1:0]  in_first_block,
  input  wire logic [bea_pkg::ADDR_W-1:0]  in_last_block,
  input  wire logic                        cfg_we,
  input  wire logic                        cfg_index,
  input  wire logic [bea_pkg::ADDR_W-1:0]  cfg_data,
  output logic                             out_valid,
  output logic [bea_pkg::STATUS_W-1:0]     out_status,
  output logic [bea_pkg::ADDR_W-1:0]       out_conflict_block,
  output logic [bea_pkg::COUNT_W-1:0]      out_marked_count,
  output logic [bea_pkg::ADDR_W-1:0]       out_run_start,
  output logic [bea_pkg::COUNT_W-1:0]      out_run_length,
  output logic                             out_last
);
  import bea_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t st;

  // sequencer
  bea_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .st    (st),
    .cmd   (cmd)
  );

  // map, walk and result datapath
  bea_datapath #(
    .BLOCKS (BLOCKS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .st                 (st),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_opcode          (in_opcode),
    .in_first_block     (in_first_block),
    .in_last_block      (in_last_block),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_conflict_block (out_conflict_block),
    .out_marked_count   (out_marked_count),
    .out_run_start      (out_run_start),
    .out_run_length     (out_run_length),
    .out_last           (out_last)
  );

endmodule

`default_nettype wire

/* test/bea_checker.sv */
`timescale 1ns / 1ps

// Watches the command, configuration and result channels of the extent
// allocator, keeps its own copy of the used/free map and the region registers,
// and compares every result against the oldest one still due.
module bea_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic                            busy,
  input  logic                            in_opcode,
  input  logic [bea_pkg::ADDR_W-1:0]      in_first_block,
  input  logic [bea_pkg::ADDR_W-1:0]      in_last_block,
  input  logic                            cfg_we,
  input  logic                            cfg_index,
  input  logic [bea_pkg::ADDR_W-1:0]      cfg_data,
  input  logic                            out_valid,
  input  logic [bea_pkg::STATUS_W-1:0]    out_status,
  input  logic [bea_pkg::ADDR_W-1:0]      out_conflict_block,
  input  logic [bea_pkg::COUNT_W-1:0]     out_marked_count,
  input  logic [bea_pkg::ADDR_W-1:0]      out_run_start,
  input  logic [bea_pkg::COUNT_W-1:0]     out_run_length,
  input  logic                            out_last,
  output int                              fail_count,
  output int                              results_due
);
  import bea_pkg::*;

  typedef struct packed {
    status_t              status;
    logic [ADDR_W-1:0]    conflict_block;
    logic [COUNT_W-1:0]   marked_count;
    logic [ADDR_W-1:0]    run_start;
    logic [COUNT_W-1:0]   run_length;
    logic                 last;
  } extent_result_t;

  extent_result_t          due_results[$];
  logic [BLOCKS_DEF-1:0]   block_used;
  logic [ADDR_W-1:0]       region_first;
  logic [ADDR_W-1:0]       region_last;
  int                      mismatches = 0;

  // Works out the results of one accepted transaction and updates the map copy
  task automatic predict_extent_results(input logic op, input logic [ADDR_W-1:0] fb,
                                        input logic [ADDR_W-1:0] lb);
    extent_result_t      res;
    extent_result_t      held;
    logic [7:0]          b;
    logic [7:0]          run_len;
    logic [ADDR_W-1:0]   run_first;
    logic                have_run;
    logic                stopped;
    res = '0;
    res.status = ST_OK;
    res.last = 1'b1;
    if (op == OP_ALLOC) begin
      // reversed range is empty and answers ok; refusal is checked after it
      if (fb <= lb) begin
        if (fb < region_first || lb > region_last || region_first > region_last) begin
          res.status = ST_OUTSIDE;
        end else begin
          stopped = 1'b0;
          for (b = {1'b0, fb}; b <= {1'b0, lb} && !stopped; b++) begin
            if (block_used[b]) begin
              res.status = ST_CONFLICT;
              res.conflict_block = b[ADDR_W-1:0];
              stopped = 1'b1;
            end else begin
              block_used[b] = 1'b1;
              res.marked_count = res.marked_count + 1'b1;
            end
          end
        end
      end
      due_results.push_back(res);
    end else begin
      // one result per maximal free run; each is held back until we know
      // whether it is the final one
      have_run = 1'b0;
      run_len = '0;
      run_first = '0;
      held = '0;
      if (region_first <= region_last) begin
        for (b = {1'b0, region_first}; b <= {1'b0, region_last}; b++) begin
          if (!block_used[b]) begin
            if (run_len == 0) run_first = b[ADDR_W-1:0];
            run_len = run_len + 1'b1;
          end
          if ((block_used[b] || b == {1'b0, region_last}) && run_len != 0) begin
            if (have_run) due_results.push_back(held);
            held = '0;
            held.run_start = run_first;
            held.run_length = run_len;
            have_run = 1'b1;
            run_len = '0;
          end
        end
      end
      // nothing free gives the single zero-length result
      if (have_run) begin
        held.last = 1'b1;
        due_results.push_back(held);
      end else begin
        due_results.push_back(res);
      end
    end
  endtask

  always @(posedge clk) begin : watch
    extent_result_t want;
    if (!rst_n) begin
      due_results.delete();
      block_used = '0;
      region_first = REGION_FIRST_RST;
      region_last = REGION_LAST_RST;
    end else begin
      // result side: compare with the oldest expectation
      if (out_valid) begin
        if (due_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: status %0d conflict %0d marked %0d run %0d len %0d last %0d",
                     out_status, out_conflict_block, out_marked_count, out_run_start,
                     out_run_length, out_last);
        end else begin
          want = due_results.pop_front();
          if (out_status !== want.status || out_conflict_block !== want.conflict_block ||
              out_marked_count !== want.marked_count || out_run_start !== want.run_start ||
              out_run_length !== want.run_length || out_last !== want.last) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("result mismatch at %0t", $realtime);
              $display("  expected status %0d conflict %0d marked %0d run %0d len %0d last %0d",
                       want.status, want.conflict_block, want.marked_count, want.run_start,
                       want.run_length, want.last);
              $display("  actual   status %0d conflict %0d marked %0d run %0d len %0d last %0d",
                       out_status, out_conflict_block, out_marked_count, out_run_start,
                       out_run_length, out_last);
            end
          end
        end
      end
      // region register writes
      if (cfg_we) begin
        if (cfg_index == CFG_REGION_FIRST) region_first = cfg_data;
        else region_last = cfg_data;
      end
      // command side
      if (start && !busy) predict_extent_results(in_opcode, in_first_block, in_last_block);
    end
    results_due <= due_results.size();
    fail_count <= mismatches;
  end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import bea_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int PHASE_ITEMS  = 103;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  in_opcode = OP_ALLOC;
  logic [ADDR_W-1:0]     in_first_block = '0;
  logic [ADDR_W-1:0]     in_last_block = '0;
  logic                  cfg_we = 1'b0;
  logic                  cfg_index = CFG_REGION_FIRST;
  logic [ADDR_W-1:0]     cfg_data = '0;

  wire                   busy;
  wire                   out_valid;
  wire [STATUS_W-1:0]    out_status;
  wire [ADDR_W-1:0]      out_conflict_block;
  wire [COUNT_W-1:0]     out_marked_count;
  wire [ADDR_W-1:0]      out_run_start;
  wire [COUNT_W-1:0]     out_run_length;
  wire                   out_last;

  int                    fail_count;
  int                    results_due;
  int                    cycle_count = 0;
  int                    idle_pct = 0;
  logic [ADDR_W-1:0]     cur_first = REGION_FIRST_RST;
  logic [ADDR_W-1:0]     cur_last = REGION_LAST_RST;

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  block_bitmap_extent_allocator #(.BLOCKS(BLOCKS_DEF)) uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_opcode          (in_opcode),
    .in_first_block     (in_first_block),
    .in_last_block      (in_last_block),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_conflict_block (out_conflict_block),
    .out_marked_count   (out_marked_count),
    .out_run_start      (out_run_start),
    .out_run_length     (out_run_length),
    .out_last           (out_last)
  );

  bea_checker extent_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_opcode          (in_opcode),
    .in_first_block     (in_first_block),
    .in_last_block      (in_last_block),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_conflict_block (out_conflict_block),
    .out_marked_count   (out_marked_count),
    .out_run_start      (out_run_start),
    .out_run_length     (out_run_length),
    .out_last           (out_last),
    .fail_count         (fail_count),
    .results_due        (results_due)
  );

  task automatic tick(input int n);
    repeat (n) @(posedge clk);
  endtask

  // Present one command and hold it until the block takes it; start stays high
  task automatic send(input logic op, input logic [ADDR_W-1:0] fb,
                      input logic [ADDR_W-1:0] lb);
    in_opcode <= op;
    in_first_block <= fb;
    in_last_block <= lb;
    start <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  // Random sender gap after a transaction, short mostly, sometimes a full walk
  task automatic sender_gap();
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      if ($urandom_range(9) == 0) tick($urandom_range(140, 20));
      else tick($urandom_range(5, 1));
    end
  endtask

  // Stop sending until every result is in and the block is idle
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (results_due != 0 || busy) @(posedge clk);
    tick(2);
  endtask

  // Both region registers; only called while idle
  task automatic write_region(input logic [ADDR_W-1:0] first, input logic [ADDR_W-1:0] last);
    cfg_we <= 1'b1;
    cfg_index <= CFG_REGION_FIRST;
    cfg_data <= first;
    @(posedge clk);
    cfg_index <= CFG_REGION_LAST;
    cfg_data <= last;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_first = first;
    cur_last = last;
  endtask

  // Run limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("block_bitmap_extent_allocator regression: fail");
    $finish;
  end

  initial begin
    int phase;
    int i;
    int pick;
    int fb;
    int lb;
    int lo;

    tick(6);
    rst_n <= 1'b1;
    // wait out the map clearing pass
    tick(2);
    while (busy) @(posedge clk);

    // directed: full region, edge blocks, conflicts and fragmented reports
    send(OP_REPORT, 7'd0, 7'd0);
    send(OP_ALLOC, 7'd127, 7'd127);
    send(OP_ALLOC, 7'd0, 7'd0);
    send(OP_REPORT, 7'd127, 7'd127);
    send(OP_ALLOC, 7'd10, 7'd5);
    send(OP_ALLOC, 7'd64, 7'd66);
    send(OP_ALLOC, 7'd60, 7'd70);
    send(OP_ALLOC, 7'd0, 7'd127);
    send(OP_REPORT, 7'd0, 7'd127);
    drain();

    // fully used region, and ranges past each end of it
    write_region(7'd60, 7'd66);
    send(OP_REPORT, 7'd0, 7'd0);
    send(OP_ALLOC, 7'd59, 7'd61);
    send(OP_ALLOC, 7'd66, 7'd67);
    send(OP_ALLOC, 7'd62, 7'd61);
    drain();

    // empty region: first above last
    write_region(7'd100, 7'd20);
    send(OP_REPORT, 7'd0, 7'd0);
    send(OP_ALLOC, 7'd30, 7'd40);
    send(OP_ALLOC, 7'd40, 7'd30);
    send(OP_ALLOC, 7'd127, 7'd127);
    drain();

    // single-block regions at both ends of the map
    write_region(7'd127, 7'd127);
    send(OP_ALLOC, 7'd127, 7'd127);
    send(OP_REPORT, 7'd0, 7'd0);
    drain();
    write_region(7'd0, 7'd0);
    send(OP_REPORT, 7'd0, 7'd0);
    send(OP_ALLOC, 7'd0, 7'd0);
    drain();

    // random phases: no idling, sender idle 64%, no idling, sender idle 35%
    for (phase = 0; phase < 4; phase++) begin
      idle_pct = (phase == 1) ? 64 : (phase == 3) ? 35 : 0;
      if (phase == 2) begin
        lo = $urandom_range(100);
        write_region(lo[ADDR_W-1:0], 7'($urandom_range(127, lo)));
      end else begin
        write_region(7'd0, 7'd127);
      end
      for (i = 0; i < PHASE_ITEMS; i++) begin
        pick = $urandom_range(99);
        if (pick < 35) begin
          send(OP_REPORT, 7'($urandom_range(127)), 7'($urandom_range(127)));
        end else if (pick < 75 && cur_first <= cur_last) begin
          // short in-region extent, occasionally spilling past the end
          fb = $urandom_range(cur_last, cur_first);
          lb = fb + (($urandom_range(1) == 0) ? 0 : $urandom_range(7, 1));
          if (lb > 127) lb = 127;
          send(OP_ALLOC, fb[ADDR_W-1:0], lb[ADDR_W-1:0]);
        end else if (pick < 85) begin
          fb = $urandom_range(127, 1);
          lb = $urandom_range(fb - 1);
          send(OP_ALLOC, fb[ADDR_W-1:0], lb[ADDR_W-1:0]);
        end else begin
          send(OP_ALLOC, 7'($urandom_range(127)), 7'($urandom_range(127)));
        end
        // now and then hold off until everything has come back
        if ($urandom_range(49) == 0) drain();
        else sender_gap();
      end
      drain();
    end

    // catch any stray results after the last expected one
    tick(BLOCKS_DEF + 16);
    if (fail_count == 0 && results_due == 0) begin
      $display("block_bitmap_extent_allocator regression: pass");
    end else begin
      $display("block_bitmap_extent_allocator regression: fail");
    end
    $finish;
  end

endmodule
